### sv/atlc_pkg.sv
package atlc_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned CfgNum = 8;
  localparam int unsigned CfgIdxW = $clog2(CfgNum);

  typedef logic [CountW-1:0] count_t;

  typedef enum logic [2:0] {
    PH_NS_GREEN  = 3'd0,
    PH_NS_YELLOW = 3'd1,
    PH_WALK_A    = 3'd2,
    PH_EW_GREEN  = 3'd3,
    PH_EW_YELLOW = 3'd4,
    PH_WALK_B    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    LAMP_RED    = 2'd0,
    LAMP_YELLOW = 2'd1,
    LAMP_GREEN  = 2'd2
  } lamp_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_YELLOW_SECONDS = 3'd0,
    CFG_WALK_SECONDS   = 3'd1,
    CFG_MAX_COUNT      = 3'd2,
    CFG_LIGHT_LIMIT    = 3'd3,
    CFG_MEDIUM_LIMIT   = 3'd4,
    CFG_GREEN_LIGHT    = 3'd5,
    CFG_GREEN_MEDIUM   = 3'd6,
    CFG_GREEN_HEAVY    = 3'd7
  } cfg_idx_e;

  // register reset values
  localparam count_t RstYellow      = 8'd3;
  localparam count_t RstWalk        = 8'd8;
  localparam count_t RstMaxCount    = 8'd10;
  localparam count_t RstLightLimit  = 8'd3;
  localparam count_t RstMediumLimit = 8'd7;
  localparam count_t RstGreenLight  = 8'd10;
  localparam count_t RstGreenMedium = 8'd20;
  localparam count_t RstGreenHeavy  = 8'd30;

  // phase timer after reset: light-traffic green
  localparam count_t RstRemaining   = 8'd10;

  typedef struct packed {
    count_t yellow_seconds;
    count_t walk_seconds;
    count_t max_count;
    count_t light_limit;
    count_t medium_limit;
    count_t green_light;
    count_t green_medium;
    count_t green_heavy;
  } cfg_t;

  typedef struct packed {
    logic ns_button;
    logic ew_button;
    logic walk_button;
  } btn_t;

  typedef struct packed {
    phase_e phase;
    count_t remaining;
    count_t ns_cars;
    count_t ew_cars;
    logic   walk_request;
    logic   prev_ns_level;
    logic   prev_ew_level;
    logic   prev_walk_level;
  } state_t;

  typedef struct packed {
    lamp_e  ns_lamp;
    lamp_e  ew_lamp;
    logic   walk_on;
    phase_e phase_now;
    count_t ticks_left;
    count_t ns_waiting;
    count_t ew_waiting;
    logic   walk_pending;
  } result_t;

endpackage

### sv/atlc_if.sv
interface atlc_in_if;
  logic valid;
  logic ready;
  logic ns_button;
  logic ew_button;
  logic walk_button;

  modport source (output valid, output ns_button, output ew_button, output walk_button,
                  input ready);
  modport sink (input valid, input ns_button, input ew_button, input walk_button,
                output ready);
endinterface

interface atlc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] ns_lamp;
  logic [1:0] ew_lamp;
  logic       walk_on;
  logic [2:0] phase_now;
  logic [7:0] ticks_left;
  logic [7:0] ns_waiting;
  logic [7:0] ew_waiting;
  logic       walk_pending;

  modport source (output valid, output ns_lamp, output ew_lamp, output walk_on,
                  output phase_now, output ticks_left, output ns_waiting,
                  output ew_waiting, output walk_pending, input ready);
  modport sink (input valid, input ns_lamp, input ew_lamp, input walk_on,
                input phase_now, input ticks_left, input ns_waiting,
                input ew_waiting, input walk_pending, output ready);
endinterface

### sv/atlc_cfg_regs.sv
module atlc_cfg_regs
  import atlc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CountW-1:0]    cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_YELLOW_SECONDS: cfg_d.yellow_seconds = cfg_data_i;
        CFG_WALK_SECONDS:   cfg_d.walk_seconds   = cfg_data_i;
        CFG_MAX_COUNT:      cfg_d.max_count      = cfg_data_i;
        CFG_LIGHT_LIMIT:    cfg_d.light_limit    = cfg_data_i;
        CFG_MEDIUM_LIMIT:   cfg_d.medium_limit   = cfg_data_i;
        CFG_GREEN_LIGHT:    cfg_d.green_light    = cfg_data_i;
        CFG_GREEN_MEDIUM:   cfg_d.green_medium   = cfg_data_i;
        CFG_GREEN_HEAVY:    cfg_d.green_heavy    = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.yellow_seconds <= RstYellow;
      cfg_q.walk_seconds   <= RstWalk;
      cfg_q.max_count      <= RstMaxCount;
      cfg_q.light_limit    <= RstLightLimit;
      cfg_q.medium_limit   <= RstMediumLimit;
      cfg_q.green_light    <= RstGreenLight;
      cfg_q.green_medium   <= RstGreenMedium;
      cfg_q.green_heavy    <= RstGreenHeavy;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/atlc_tick_logic.sv
module atlc_tick_logic
  import atlc_pkg::*;
(
  input  state_t  st_i,
  input  cfg_t    cfg_i,
  input  btn_t    btn_i,
  output state_t  st_o,
  output result_t res_o
);

  // a zero duration counts as one tick
  function automatic count_t at_least_one(input count_t v);
    return (v == '0) ? count_t'(1) : v;
  endfunction

  function automatic count_t green_for(input count_t cars, input cfg_t c);
    count_t g;
    if (cars <= c.light_limit) begin
      g = c.green_light;
    end else if (cars <= c.medium_limit) begin
      g = c.green_medium;
    end else begin
      g = c.green_heavy;
    end
    return at_least_one(g);
  endfunction

  logic   ns_press, ew_press, walk_press;
  count_t ns_cars, ew_cars;
  logic   walk_req;
  phase_e next_ph;

  always_comb begin
    ns_press   = st_i.prev_ns_level & ~btn_i.ns_button;
    ew_press   = st_i.prev_ew_level & ~btn_i.ew_button;
    walk_press = st_i.prev_walk_level & ~btn_i.walk_button;

    ns_cars  = (ns_press && (st_i.ns_cars < cfg_i.max_count)) ?
               st_i.ns_cars + count_t'(1) : st_i.ns_cars;
    ew_cars  = (ew_press && (st_i.ew_cars < cfg_i.max_count)) ?
               st_i.ew_cars + count_t'(1) : st_i.ew_cars;
    walk_req = st_i.walk_request | walk_press;

    st_o                 = st_i;
    st_o.prev_ns_level   = btn_i.ns_button;
    st_o.prev_ew_level   = btn_i.ew_button;
    st_o.prev_walk_level = btn_i.walk_button;
    next_ph              = st_i.phase;

    if (st_i.remaining > count_t'(1)) begin
      st_o.remaining = st_i.remaining - count_t'(1);
    end else begin
      // end-of-phase actions, then pick the successor
      case (st_i.phase)
        PH_NS_GREEN:  ns_cars  = '0;
        PH_EW_GREEN:  ew_cars  = '0;
        PH_WALK_A,
        PH_WALK_B:    walk_req = 1'b0;
        default:      ;
      endcase
      case (st_i.phase)
        PH_NS_GREEN:  next_ph = PH_NS_YELLOW;
        PH_NS_YELLOW: next_ph = walk_req ? PH_WALK_A : PH_EW_GREEN;
        PH_WALK_A:    next_ph = PH_EW_GREEN;
        PH_EW_GREEN:  next_ph = PH_EW_YELLOW;
        PH_EW_YELLOW: next_ph = walk_req ? PH_WALK_B : PH_NS_GREEN;
        default:      next_ph = PH_NS_GREEN;
      endcase
      case (next_ph)
        PH_NS_GREEN:  st_o.remaining = green_for(ns_cars, cfg_i);
        PH_EW_GREEN:  st_o.remaining = green_for(ew_cars, cfg_i);
        PH_NS_YELLOW,
        PH_EW_YELLOW: st_o.remaining = at_least_one(cfg_i.yellow_seconds);
        default:      st_o.remaining = at_least_one(cfg_i.walk_seconds);
      endcase
    end

    st_o.phase        = next_ph;
    st_o.ns_cars      = ns_cars;
    st_o.ew_cars      = ew_cars;
    st_o.walk_request = walk_req;
  end

  always_comb begin
    res_o.ns_lamp = LAMP_RED;
    res_o.ew_lamp = LAMP_RED;
    res_o.walk_on = 1'b0;
    case (next_ph)
      PH_NS_GREEN:  res_o.ns_lamp = LAMP_GREEN;
      PH_NS_YELLOW: res_o.ns_lamp = LAMP_YELLOW;
      PH_EW_GREEN:  res_o.ew_lamp = LAMP_GREEN;
      PH_EW_YELLOW: res_o.ew_lamp = LAMP_YELLOW;
      default:      res_o.walk_on = 1'b1;
    endcase
    res_o.phase_now    = next_ph;
    res_o.ticks_left   = st_o.remaining;
    res_o.ns_waiting   = st_o.ns_cars;
    res_o.ew_waiting   = st_o.ew_cars;
    res_o.walk_pending = st_o.walk_request;
  end

endmodule

### sv/adaptive_traffic_light_controller_core.sv
// A tick transaction accepted into the input register passes through the tick
// logic into the controller state and result register.
// Throughput: one tick transaction per cycle while the output side keeps up;
// set by the single pass through the tick logic between the input and result registers.
// Reset (async, active low): NS green with 10 ticks left, counts and walk
// request cleared, buttons seen as released, registers at their defaults.
module adaptive_traffic_light_controller_core
  import atlc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  atlc_in_if.sink            in_i,
  atlc_out_if.source         out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CountW-1:0]  cfg_data_i
);

  cfg_t    cfg;

  // input stage
  logic    in_valid_q;
  btn_t    btn_q;
  logic    in_fire, stage_fire;

  // controller state and result stage
  state_t  st_q, st_next;
  result_t res_next, res_q;
  logic    out_valid_q, out_valid_d;

  atlc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The input stage moves on when the result register is empty or being
  // drained this cycle; that keeps a new tick flowing in every cycle while
  // the output side keeps up.
  assign stage_fire = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || stage_fire;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // payload only; captured on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      btn_q.ns_button   <= in_i.ns_button;
      btn_q.ew_button   <= in_i.ew_button;
      btn_q.walk_button <= in_i.walk_button;
    end
  end

  atlc_tick_logic u_tick_logic (
    .st_i  (st_q),
    .cfg_i (cfg),
    .btn_i (btn_q),
    .st_o  (st_next),
    .res_o (res_next)
  );

  // Controller state advances once per tick, together with the result load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase           <= PH_NS_GREEN;
      st_q.remaining       <= RstRemaining;
      st_q.ns_cars         <= '0;
      st_q.ew_cars         <= '0;
      st_q.walk_request    <= 1'b0;
      st_q.prev_ns_level   <= 1'b1;
      st_q.prev_ew_level   <= 1'b1;
      st_q.prev_walk_level <= 1'b1;
    end else if (stage_fire) begin
      st_q <= st_next;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (stage_fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_fire) begin
      res_q <= res_next;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.ns_lamp      = res_q.ns_lamp;
  assign out_o.ew_lamp      = res_q.ew_lamp;
  assign out_o.walk_on      = res_q.walk_on;
  assign out_o.phase_now    = res_q.phase_now;
  assign out_o.ticks_left   = res_q.ticks_left;
  assign out_o.ns_waiting   = res_q.ns_waiting;
  assign out_o.ew_waiting   = res_q.ew_waiting;
  assign out_o.walk_pending = res_q.walk_pending;

endmodule

### sv/atlc_checker.sv
module atlc_checker
  import atlc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  ns_lamp_i,
  input logic [1:0]  ew_lamp_i,
  input logic        walk_on_i,
  input logic [2:0]  phase_now_i,
  input logic [7:0]  ticks_left_i,
  input logic [7:0]  ns_waiting_i,
  input logic [7:0]  ew_waiting_i,
  input logic        walk_pending_i
);

  // lamps must agree with the reported phase
  a_lamps_match_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (ns_lamp_i == ((phase_now_i == PH_NS_GREEN)  ? LAMP_GREEN :
                     (phase_now_i == PH_NS_YELLOW) ? LAMP_YELLOW : LAMP_RED)) &&
      (ew_lamp_i == ((phase_now_i == PH_EW_GREEN)  ? LAMP_GREEN :
                     (phase_now_i == PH_EW_YELLOW) ? LAMP_YELLOW : LAMP_RED)))
    else $error("lamp outputs disagree with phase");

  // walk lamp on exactly in a walk phase, never both crossing directions non-red
  a_walk_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (walk_on_i == ((phase_now_i == PH_WALK_A) || (phase_now_i == PH_WALK_B))) &&
      !((ns_lamp_i != LAMP_RED) && (ew_lamp_i != LAMP_RED)))
    else $error("walk lamp or crossing lamps inconsistent");

  // the phase timer never reports zero and the phase code stays in range
  a_timer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (ticks_left_i != 8'd0) && (phase_now_i <= PH_WALK_B))
    else $error("phase timer or phase code out of range");

  // a result waiting to be taken does not change
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable(phase_now_i) && $stable(ticks_left_i) && $stable(ns_waiting_i) &&
      $stable(ew_waiting_i) && $stable(walk_pending_i))
    else $error("stalled result changed");

endmodule

bind adaptive_traffic_light_controller_core atlc_checker u_atlc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .ns_lamp_i      (out_o.ns_lamp),
  .ew_lamp_i      (out_o.ew_lamp),
  .walk_on_i      (out_o.walk_on),
  .phase_now_i    (out_o.phase_now),
  .ticks_left_i   (out_o.ticks_left),
  .ns_waiting_i   (out_o.ns_waiting),
  .ew_waiting_i   (out_o.ew_waiting),
  .walk_pending_i (out_o.walk_pending)
);
